### src/lesf_pkg.sv
// Package for the largest empty square finder: field widths, word types,
// register indexes and reset values. No dependencies.
`default_nettype none

package lesf_pkg;

	localparam int CELL_W       = 8;
	localparam int POS_W        = 10;
	localparam int SIZE_W       = 11;
	localparam int DIM_W        = 11;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 11;
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;

	typedef logic [CELL_W-1:0]     cell_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [SIZE_W-1:0]     side_t;
	typedef logic [DIM_W-1:0]      dim_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_addr_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_ROWS = 2'd0,
		CFG_MAP_COLS = 2'd1,
		CFG_OBSTACLE = 2'd2
	} cfg_idx_t;

	localparam dim_t  MAP_ROWS_RST = 11'd1;
	localparam dim_t  MAP_COLS_RST = 11'd1;
	localparam cell_t OBSTACLE_RST = 8'd111;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

### src/lesf_ifs.sv
// Handshake interfaces of the largest empty square finder: configuration
// writes, map cells in, square results out. Depends on lesf_pkg.
`default_nettype none

interface lesf_cfg_if;
	import lesf_pkg::*;
	logic      valid;
	logic      ready;
	cfg_addr_t index;
	cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface lesf_in_if;
	import lesf_pkg::*;
	logic  valid;
	logic  ready;
	cell_t cell_char;
	modport source (output valid, output cell_char, input ready);
	modport sink   (input valid, input cell_char, output ready);
endinterface

interface lesf_out_if;
	import lesf_pkg::*;
	logic  valid;
	logic  ready;
	pos_t  best_row;
	pos_t  best_col;
	side_t best_size;
	modport source (output valid, output best_row, output best_col, output best_size,
		input ready);
	modport sink   (input valid, input best_row, input best_col, input best_size,
		output ready);
endinterface

`default_nettype wire

### src/largest_empty_square_finder.sv
// A map's result is registered in stage 1 and then in the output register after its
// last cell word is accepted. Throughput: one cell word per cycle. Only the last cell
// of a map can wait: while the cell before it, in stage 1, also closed a map, and while
// a result is not taken. Reset clears counters, best square and handshake state and
// loads the config registers with their reset values; the line buffer of previous-row
// sizes is not cleared and is filled as rows stream in. Depends on lesf_pkg and lesf_ifs.
`default_nettype none

module largest_empty_square_finder #(
	parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	lesf_cfg_if.sink   cfg,
	lesf_in_if.sink    cells,
	lesf_out_if.source results
);
	import lesf_pkg::*;

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int SW = $clog2(MAX_COLS + 1);
	localparam int EW = imax(imax(CW, RW) + 1, DIM_W);
	localparam int PW = imax(imax(CW, RW) + 1, imax(SW, POS_W));

	// Configuration registers
	dim_t  map_rows_q;
	dim_t  map_cols_q;
	cell_t obstacle_q;

	// Scan position of the next cell
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Dimension clamp and row / map end detection
	logic [EW-1:0] rows_eff;
	logic [EW-1:0] cols_eff;
	logic [EW-1:0] col_inc;
	logic [EW-1:0] row_inc;
	logic          row_end;
	logic          map_end;
	logic          accept;

	// Stage 1: memory read returned, size computed
	logic          valid_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          free_s1;
	logic          end_s1;
	logic          fwd_s1;
	logic [SW-1:0] rd_s1;

	// Line buffer of previous-row sizes
	logic [SW-1:0] line_mem [MAX_COLS];

	// Neighbor history and best square
	logic [SW-1:0] last_size_q;
	logic [SW-1:0] last_up_q;
	logic [SW-1:0] top_size_q;
	logic [PW-1:0] top_row_q;
	logic [PW-1:0] top_col_q;

	logic [SW-1:0] up_s1;
	logic [SW-1:0] left_s1;
	logic [SW-1:0] diag_s1;
	logic [SW-1:0] min_s1;
	logic [SW-1:0] size_s1;
	logic          beat_s1;
	logic [PW-1:0] new_row_s1;
	logic [PW-1:0] new_col_s1;

	// Output register
	logic  out_valid_q;
	pos_t  best_row_q;
	pos_t  best_col_q;
	side_t best_size_q;

	// Take configuration writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q <= MAP_ROWS_RST;
			map_cols_q <= MAP_COLS_RST;
			obstacle_q <= OBSTACLE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAP_ROWS: map_rows_q <= cfg.data;
				CFG_MAP_COLS: map_cols_q <= cfg.data;
				CFG_OBSTACLE: obstacle_q <= cfg.data[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate dimensions and flag the last cell of a row and of the map
	always_comb begin
		rows_eff = EW'(map_rows_q);
		priority if (map_rows_q == '0) begin
			rows_eff = EW'(1);
		end else if (rows_eff > EW'(MAX_ROWS)) begin
			rows_eff = EW'(MAX_ROWS);
		end else begin
			rows_eff = EW'(map_rows_q);
		end
		cols_eff = EW'(map_cols_q);
		priority if (map_cols_q == '0) begin
			cols_eff = EW'(1);
		end else if (cols_eff > EW'(MAX_COLS)) begin
			cols_eff = EW'(MAX_COLS);
		end else begin
			cols_eff = EW'(map_cols_q);
		end
		col_inc = EW'(col_q) + EW'(1);
		row_inc = EW'(row_q) + EW'(1);
		row_end = (col_inc >= cols_eff);
		map_end = row_end && (row_inc >= rows_eff);
	end

	// Hold a map's last cell while another map end sits in stage 1 or the result is not taken
	assign cells.ready = !map_end || (!(valid_s1 && end_s1) && (!out_valid_q || results.ready));
	assign accept      = cells.valid && cells.ready;

	// Advance scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= map_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Capture cell word into stage 1; flag a read that races the pending write
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_q;
			row_s1  <= row_q;
			free_s1 <= (cells.cell_char != obstacle_q);
			end_s1  <= map_end;
			fwd_s1  <= valid_s1 && (col_s1 == col_q);
		end
	end

	// Line buffer: write stage 1 result, read the column of the new cell
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1] <= size_s1;
		end
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
	end

	// Size of the square ending at this cell: 1 + min(up, left, diagonal) if free, else 0
	always_comb begin
		up_s1   = '0;
		left_s1 = '0;
		diag_s1 = '0;
		if (row_s1 != '0) begin
			up_s1 = fwd_s1 ? last_size_q : rd_s1;
		end
		if (col_s1 != '0) begin
			left_s1 = last_size_q;
			if (row_s1 != '0) begin
				diag_s1 = last_up_q;
			end
		end
		min_s1 = (up_s1 < left_s1) ? up_s1 : left_s1;
		if (diag_s1 < min_s1) begin
			min_s1 = diag_s1;
		end
		size_s1    = free_s1 ? min_s1 + SW'(1) : '0;
		beat_s1    = (size_s1 > top_size_q);
		new_row_s1 = PW'(row_s1) + PW'(1) - PW'(size_s1);
		new_col_s1 = PW'(col_s1) + PW'(1) - PW'(size_s1);
	end

	// Track neighbors and the best square; drop it at map end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_size_q <= '0;
			last_up_q   <= '0;
			top_size_q  <= '0;
			top_row_q   <= '0;
			top_col_q   <= '0;
		end else if (valid_s1) begin
			last_size_q <= size_s1;
			last_up_q   <= up_s1;
			if (end_s1) begin
				top_size_q <= '0;
				top_row_q  <= '0;
				top_col_q  <= '0;
			end else if (beat_s1) begin
				top_size_q <= size_s1;
				top_row_q  <= new_row_s1;
				top_col_q  <= new_col_s1;
			end
		end
	end

	// Output register: load at map end, drop when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && end_s1) begin
			if (beat_s1) begin
				best_row_q  <= new_row_s1[POS_W-1:0];
				best_col_q  <= new_col_s1[POS_W-1:0];
				best_size_q <= SIZE_W'(size_s1);
			end else begin
				best_row_q  <= top_row_q[POS_W-1:0];
				best_col_q  <= top_col_q[POS_W-1:0];
				best_size_q <= SIZE_W'(top_size_q);
			end
		end
	end

	assign results.valid     = out_valid_q;
	assign results.best_row  = best_row_q;
	assign results.best_col  = best_col_q;
	assign results.best_size = best_size_q;

endmodule

`default_nettype wire

### tb/largest_empty_square_finder_test.sv
// Self-checking testbench for largest_empty_square_finder: streams map cells,
// predicts each map's largest free square and checks every result word.
// Depends on lesf_pkg, lesf_ifs and the largest_empty_square_finder RTL.
`default_nettype none

module largest_empty_square_finder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lesf_pkg::*;

	localparam int MAX_COLS = DEF_MAX_COLS;
	localparam int MAX_ROWS = DEF_MAX_ROWS;
	localparam int SETTLE   = 4;
	localparam int HOLD_LEN = 400;

	typedef struct packed {
		pos_t  row;
		pos_t  col;
		side_t side;
	} square_t;

	logic clk = 1'b0;
	logic arst_n;

	lesf_cfg_if cfg_bus ();
	lesf_in_if  cell_bus ();
	lesf_out_if square_bus ();

	largest_empty_square_finder #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cells  (cell_bus),
		.results(square_bus)
	);

	always #2 clk = ~clk;

	// Square finder shadow: configuration, line buffer and scan position
	dim_t  cfg_rows  = MAP_ROWS_RST;
	dim_t  cfg_cols  = MAP_COLS_RST;
	cell_t cfg_block = OBSTACLE_RST;
	int    line_sizes [MAX_COLS];
	int    lines_filled = 0;
	int    run_left = 0;
	int    run_diag = 0;
	int    at_col = 0;
	int    at_row = 0;
	int    lead_size = 0;
	int    lead_row = 0;
	int    lead_col = 0;

	cell_t   pending_cells [$];
	square_t expected_squares [$];

	int mismatches = 0;
	int words_sent = 0;
	int squares_checked = 0;
	int reg_writes = 0;
	int block_mix [5] = '{0, 15, 35, 70, 100};

	int burst_left = 0;
	int gap_left = 0;
	int pace_left = 0;
	int pace_mode = 0;
	int hold_left = 0;
	bit hold_armed = 1'b0;
	bit hold_taken = 1'b0;

	function automatic int fit_dim(input dim_t v, input int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// Advance the shadow by one cell; return 1 when the map closes
	function automatic bit scan_cell(input cell_t ch, output square_t sq);
		int rows, cols, up, left, diag, side;
		rows = fit_dim(cfg_rows, MAX_ROWS);
		cols = fit_dim(cfg_cols, MAX_COLS);
		up = 0;
		left = 0;
		diag = 0;
		side = 0;
		sq = '0;
		if (at_row > 0 && at_col < MAX_COLS)
			up = line_sizes[at_col];
		if (at_col > 0) begin
			left = run_left;
			if (at_row > 0)
				diag = run_diag;
		end
		if (ch != cfg_block) begin
			side = (up < left) ? up : left;
			side = 1 + ((side < diag) ? side : diag);
		end
		// strictly larger only, so ties keep the earliest corner
		if (side > lead_size) begin
			lead_size = side;
			lead_row = at_row + 1 - side;
			lead_col = at_col + 1 - side;
		end
		if (at_col < MAX_COLS) begin
			line_sizes[at_col] = side;
			if (at_col >= lines_filled)
				lines_filled = at_col + 1;
		end
		run_left = side;
		run_diag = up;
		if (at_col + 1 >= cols) begin
			at_col = 0;
			run_left = 0;
			run_diag = 0;
			if (at_row + 1 >= rows) begin
				sq.row = pos_t'(lead_row);
				sq.col = pos_t'(lead_col);
				sq.side = side_t'(lead_size);
				at_row = 0;
				lead_size = 0;
				lead_row = 0;
				lead_col = 0;
				return 1'b1;
			end
			at_row = at_row + 1;
		end else begin
			at_col = at_col + 1;
		end
		return 1'b0;
	endfunction

	// Cells still needed to close the current map under the present dimensions
	function automatic int cells_to_map_end();
		int rows, cols, n;
		rows = fit_dim(cfg_rows, MAX_ROWS);
		cols = fit_dim(cfg_cols, MAX_COLS);
		n = (at_col >= cols - 1) ? 1 : cols - at_col;
		if (at_row < rows - 1)
			n += (rows - 1 - at_row) * cols;
		return n;
	endfunction

	function automatic dim_t pick_dim();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return dim_t'(0);
		if (roll < 65)
			return dim_t'($urandom_range(1, 4));
		return dim_t'($urandom_range(5, 12));
	endfunction

	function automatic cell_t pick_cell(input int block_pct);
		if ($urandom_range(0, 99) < block_pct)
			return cfg_block;
		return cell_t'($urandom_range(0, 255));
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic push_cells(input int count, input int block_pct);
		repeat (count) pending_cells.push_back(pick_cell(block_pct));
	endtask

	// All blocked but the last cell, so the corner lands at the far end
	task automatic push_sparse_map(input int count);
		repeat (count - 1) pending_cells.push_back(cfg_block);
		pending_cells.push_back(cfg_block ^ 8'h01);
	endtask

	// Hold until every word is taken and every square has come back
	task automatic settle_block();
		while (pending_cells.size() != 0 || cell_bus.valid || expected_squares.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_MAP_ROWS: cfg_rows = dim_t'(val);
			CFG_MAP_COLS: cfg_cols = dim_t'(val);
			CFG_OBSTACLE: cfg_block = cell_t'(val);
			default: ;
		endcase
	endtask

	task automatic set_map(input dim_t rows, input dim_t cols, input cell_t block_char);
		cfg_data_t noise;
		noise = cfg_data_t'($urandom_range(0, 7)) << CELL_W;
		write_reg(CFG_MAP_ROWS, cfg_data_t'(rows));
		write_reg(CFG_MAP_COLS, cfg_data_t'(cols));
		write_reg(CFG_OBSTACLE, noise | cfg_data_t'(block_char));
	endtask

	// Cell driver: bursts of words with random gaps, fed from pending_cells
	always @(posedge clk) begin
		logic    next_valid;
		cell_t   next_char;
		square_t sq;
		if (!arst_n) begin
			cell_bus.valid <= 1'b0;
			cell_bus.cell_char <= '0;
		end else begin
			if (cell_bus.valid && cell_bus.ready) begin
				words_sent++;
				if (scan_cell(cell_bus.cell_char, sq))
					expected_squares.push_back(sq);
			end
			next_valid = cell_bus.valid;
			next_char = cell_bus.cell_char;
			if (!(cell_bus.valid && !cell_bus.ready)) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cells.size() != 0) begin
					next_valid = 1'b1;
					next_char = pending_cells.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			cell_bus.valid <= next_valid;
			cell_bus.cell_char <= next_char;
		end
	end

	// Long hold-off on the result side, armed once by the stimulus
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_armed && !hold_taken) begin
			hold_left <= HOLD_LEN;
			hold_taken <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result receiver: stall pattern switches between segments of random length
	always @(posedge clk) begin
		bit take;
		if (!arst_n) begin
			square_bus.ready <= 1'b0;
		end else begin
			if (pace_left == 0) begin
				pace_mode <= $urandom_range(0, 3);
				pace_left <= $urandom_range(20, 120);
			end else begin
				pace_left <= pace_left - 1;
			end
			case (pace_mode)
				0: take = 1'b1;
				1: take = ($urandom_range(0, 1) == 0);
				2: take = ($urandom_range(0, 3) == 0);
				default: take = ($urandom_range(0, 15) != 0);
			endcase
			square_bus.ready <= (hold_left == 0) && take;
		end
	end

	// Result monitor: compare each word with the oldest predicted square
	always @(posedge clk) begin
		square_t got, want;
		if (arst_n && square_bus.valid && square_bus.ready) begin
			got.row = square_bus.best_row;
			got.col = square_bus.best_col;
			got.side = square_bus.best_size;
			if (expected_squares.size() == 0) begin
				note_failure($sformatf("unexpected square: row %0d col %0d size %0d",
					got.row, got.col, got.side));
			end else begin
				want = expected_squares.pop_front();
				squares_checked++;
				if (got.row !== want.row || got.col !== want.col || got.side !== want.side)
					note_failure($sformatf({"square mismatch: expected row %0d col %0d size %0d,",
						" got row %0d col %0d size %0d"}, want.row, want.col, want.side,
						got.row, got.col, got.side));
			end
		end
	end

	initial begin
		int   rand_words, phase, nmaps, pct, total, part, rest;
		dim_t nr, nc;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_MAP_ROWS;
		cfg_bus.data = '0;
		cell_bus.valid = 1'b0;
		cell_bus.cell_char = '0;
		square_bus.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions: every cell is a 1x1 map; blocked, then free at both code ends
		pending_cells.push_back(OBSTACLE_RST);
		pending_cells.push_back(8'h00);
		pending_cells.push_back(8'hFF);
		settle_block();

		// Zero dimensions act as one; all-ones data gives obstacle 255
		write_reg(CFG_MAP_ROWS, 11'd0);
		write_reg(CFG_MAP_COLS, 11'd0);
		write_reg(CFG_OBSTACLE, 11'h7FF);
		pending_cells.push_back(8'hFF);
		pending_cells.push_back(8'hFE);
		settle_block();

		// Fully free 2x4 map: three equal squares, the first one wins
		set_map(11'd2, 11'd4, 8'h00);
		for (int i = 1; i <= 8; i++)
			pending_cells.push_back(cell_t'(i));
		settle_block();

		// Widen the columns partway through a map
		set_map(11'd3, 11'd2, 8'h2A);
		pending_cells.push_back(8'h2A);
		pending_cells.push_back(8'h41);
		pending_cells.push_back(8'h42);
		settle_block();
		write_reg(CFG_MAP_COLS, 11'd4);
		push_cells(cells_to_map_end(), 20);
		settle_block();

		// Narrow both dimensions partway through: the next cell closes the map
		pending_cells.push_back(8'h43);
		pending_cells.push_back(8'h2A);
		pending_cells.push_back(8'h44);
		settle_block();
		write_reg(CFG_MAP_ROWS, 11'd1);
		write_reg(CFG_MAP_COLS, 11'd2);
		pending_cells.push_back(8'h45);
		settle_block();

		// Random phases
		rand_words = 0;
		phase = 0;
		while (rand_words < 600) begin
			if (phase == 1) begin
				// stream many 1x1 maps against a long result stall
				set_map(11'd1, 11'd1, cell_t'($urandom_range(0, 255)));
				hold_armed = 1'b1;
				push_cells(80, 50);
				rand_words += 80;
			end else if (phase == 3) begin
				// oversized dimensions saturate, so a short run leaves the map open
				set_map(11'd2047, 11'd2047, cell_t'($urandom_range(0, 255)));
				push_cells(40, 30);
				settle_block();
				write_reg(CFG_MAP_ROWS, 11'd1);
				write_reg(CFG_MAP_COLS, 11'd1);
				rest = cells_to_map_end();
				push_cells(rest, 30);
				rand_words += 40 + rest;
			end else if (phase == 6) begin
				set_map(11'd1, 11'd12, cell_t'($urandom_range(0, 255)));
				push_sparse_map(12);
				rand_words += 12;
			end else begin
				set_map(pick_dim(), pick_dim(), cell_t'($urandom_range(0, 255)));
				nmaps = $urandom_range(1, 5);
				for (int m = 0; m < nmaps; m++) begin
					pct = block_mix[$urandom_range(0, 4)];
					total = fit_dim(cfg_rows, MAX_ROWS) * fit_dim(cfg_cols, MAX_COLS);
					if (total > 1 && $urandom_range(0, 3) == 0) begin
						part = $urandom_range(1, total - 1);
						push_cells(part, pct);
						settle_block();
						// widen only over line-buffer entries already written
						do begin
							nr = pick_dim();
							nc = pick_dim();
						end while (at_row != 0 && fit_dim(nc, MAX_COLS) > lines_filled);
						write_reg(CFG_MAP_ROWS, cfg_data_t'(nr));
						write_reg(CFG_MAP_COLS, cfg_data_t'(nc));
						rest = cells_to_map_end();
						push_cells(rest, pct);
						rand_words += part + rest;
					end else begin
						push_cells(total, pct);
						rand_words += total;
					end
				end
			end
			settle_block();
			phase++;
		end

		$display("Run covered %0d cell words in %0d phases, %0d register writes,",
			words_sent, phase, reg_writes);
		$display("and %0d squares checked with %0d failures.", squares_checked, mismatches);
		if (mismatches == 0) begin
			$display("largest_empty_square_finder verification clean");
		end else begin
			$display("largest_empty_square_finder verification failed");
		end
		$finish;
	end

	// Drop the run if it hangs
	initial begin
		#2_000_000;
		$display("Timeout with %0d squares still expected.", expected_squares.size());
		$display("largest_empty_square_finder verification failed");
		$finish;
	end

endmodule

`default_nettype wire
